// ----- rtl/rti_pkg.sv -----
// Shared types and constants for the ray/triangle intersection pipeline.
package rti_pkg;

   localparam int COORD_W   = 32;              // coordinate width
   localparam int E_W       = COORD_W + 1;     // edge / difference width
   localparam int VEC_W     = 2 * E_W + 1;     // cross product component width
   localparam int DOT_W     = 3 * E_W + 3;     // dot product width
   localparam int QUO_W     = 32;              // saturated quotient width
   localparam int BARY_W    = 17;
   localparam int THR_W     = 31;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;

   localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 32'sd65536;
   localparam logic [THR_W-1:0]          THR_RESET   = 31'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5,
      CSR_DET_THR  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert0_x;
      logic signed [COORD_W-1:0] vert0_y;
      logic signed [COORD_W-1:0] vert0_z;
      logic signed [COORD_W-1:0] vert1_x;
      logic signed [COORD_W-1:0] vert1_y;
      logic signed [COORD_W-1:0] vert1_z;
      logic signed [COORD_W-1:0] vert2_x;
      logic signed [COORD_W-1:0] vert2_y;
      logic signed [COORD_W-1:0] vert2_z;
   } req_data_type;

   typedef struct packed {
      logic                    hit;
      logic signed [QUO_W-1:0] hit_distance;
      logic [BARY_W-1:0]       bary_u;
      logic [BARY_W-1:0]       bary_v;
   } rsp_data_type;

   function automatic logic signed [E_W-1:0] sx(logic signed [COORD_W-1:0] a);
      return {a[COORD_W-1], a};
   endfunction

endpackage

// ----- rtl/rti_div.sv -----
// Pipelined restoring divider: trunc(num * 2^FRAC_BITS / den), saturated to 32 bits.
module rti_div import rti_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic signed [DOT_W-1:0] num,
   input  logic signed [DOT_W-1:0] den,
   output logic signed [QUO_W-1:0] quo
);

   localparam int N_W = DOT_W + FRAC_BITS;
   localparam int X_W = N_W + QUO_W;

   logic [DOT_W-1:0] num_mag;
   logic [DOT_W-1:0] den_mag;
   logic [N_W-1:0]   n_a_ff;
   logic [DOT_W-1:0] d_a_ff;
   logic             neg_a_ff;

   logic [N_W-1:0]   r_ff   [QUO_W+1];
   logic [DOT_W-1:0] d_ff   [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];

   logic [QUO_W-1:0]        lim;
   logic [QUO_W-1:0]        mag;
   logic signed [QUO_W-1:0] quo_ff;

   assign num_mag = num[DOT_W-1] ? DOT_W'(-num) : num;
   assign den_mag = den[DOT_W-1] ? DOT_W'(-den) : den;

   always_ff @(posedge clock) begin
      n_a_ff   <= {num_mag, {FRAC_BITS{1'b0}}};
      d_a_ff   <= den_mag;
      neg_a_ff <= num[DOT_W-1] ^ den[DOT_W-1];
   end

   // anything at or above den << 32 can only saturate
   always_ff @(posedge clock) begin
      r_ff[0]   <= n_a_ff;
      d_ff[0]   <= d_a_ff;
      q_ff[0]   <= '0;
      neg_ff[0] <= neg_a_ff;
      ovf_ff[0] <= {{QUO_W{1'b0}}, n_a_ff} >=
                   {{FRAC_BITS{1'b0}}, d_a_ff, {QUO_W{1'b0}}};
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int SH = QUO_W - 1 - k;
      logic [X_W-1:0] r_x;
      logic [X_W-1:0] trial;
      logic [X_W-1:0] diff;
      logic           ge;

      assign r_x   = {{QUO_W{1'b0}}, r_ff[k]};
      assign trial = {{(X_W-DOT_W){1'b0}}, d_ff[k]} << SH;
      assign ge    = r_x >= trial;
      assign diff  = r_x - trial;

      always_ff @(posedge clock) begin
         r_ff[k+1]   <= ge ? diff[N_W-1:0] : r_ff[k];
         d_ff[k+1]   <= d_ff[k];
         q_ff[k+1]   <= {q_ff[k][QUO_W-2:0], ge};
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   always_comb begin
      lim = neg_ff[QUO_W] ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
      mag = (ovf_ff[QUO_W] || q_ff[QUO_W] > lim) ? lim : q_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      quo_ff <= neg_ff[QUO_W] ? -mag : mag;
   end

   assign quo = quo_ff;

endmodule

// ----- rtl/ray_triangle_intersect.sv -----
// Top level: fixed-point ray/triangle intersection pipeline.
//
//  channel  ports                          handshake
//  request  start, busy, req_data          taken when start && !busy
//  result   rsp_valid, rsp_data            one-cycle strobe, no backpressure
//  csr      csr_we, csr_index, csr_wdata   write when csr_we
//
// One triangle per cycle; each result passes through 6 arithmetic stages,
// 35 registers in the quotient dividers and one output register.
// The dividers retire one quotient bit per stage, which sets the depth.
// busy stays low: the pipeline always advances. Synchronous reset clears
// the valid bits and loads the ray registers with their reset values.
module ray_triangle_intersect import rti_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   output rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int PP_W    = 2 * E_W + 1;
   localparam int SUM_W   = PP_W + 2;
   localparam int DIV_LAT = QUO_W + 3;
   localparam int LATENCY = 6 + DIV_LAT + 1;
   localparam int DOT_DET = 0;
   localparam int DOT_U   = 1;
   localparam int DOT_V   = 2;
   localparam int DOT_T   = 3;

   function automatic logic signed [SUM_W-1:0] sx2(logic signed [PP_W-1:0] a);
      return {{2{a[PP_W-1]}}, a};
   endfunction

   // ray registers
   logic signed [COORD_W-1:0] org_ff [3];
   logic signed [COORD_W-1:0] dir_ff [3];
   logic [THR_W-1:0]          thr_ff;

   logic accept;

   logic signed [COORD_W-1:0] vin0 [3];
   logic signed [COORD_W-1:0] vin1 [3];
   logic signed [COORD_W-1:0] vin2 [3];
   logic signed [E_W-1:0]     dext [3];

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [E_W-1:0] e1_1_ff [3], e2_1_ff [3], tv_1_ff [3];
   logic signed [E_W-1:0] e1_2_ff [3], e2_2_ff [3], tv_2_ff [3];
   logic signed [E_W-1:0] e1_3_ff [3], e2_3_ff [3], tv_3_ff [3];

   logic signed [2*E_W-1:0] pa_ff [3], pb_ff [3], qa_ff [3], qb_ff [3];
   logic signed [VEC_W-1:0] pvec_ff [3], qvec_ff [3];

   logic signed [E_W-1:0]   nar    [4][3];
   logic signed [VEC_W-1:0] wid    [4][3];
   logic signed [E_W:0]     lo_op  [4][3];
   logic signed [E_W:0]     hi_op  [4][3];
   logic signed [PP_W-1:0]  lo_ff  [4][3];
   logic signed [PP_W-1:0]  hi_ff  [4][3];
   logic signed [SUM_W-1:0] lo_sum_ff [4];
   logic signed [SUM_W-1:0] hi_sum_ff [4];
   logic signed [DOT_W-1:0] dot_ff [4];

   logic [DOT_W-1:0] det_mag;
   logic [DOT_W-1:0] thr_ext;
   logic             det_ok;
   logic             vd_ff [DIV_LAT];
   logic             ok_ff [DIV_LAT];

   logic signed [QUO_W-1:0] quo_u, quo_v, quo_t;
   logic [QUO_W-1:0]        one_q;
   logic [QUO_W:0]          uv_sum;
   logic                    u_ok, v_ok, hit;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= DIR_Z_RESET;
         thr_ff    <= THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: org_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y: org_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z: org_ff[2] <= csr_wdata;
            CSR_DIR_X:    dir_ff[0] <= csr_wdata;
            CSR_DIR_Y:    dir_ff[1] <= csr_wdata;
            CSR_DIR_Z:    dir_ff[2] <= csr_wdata;
            CSR_DET_THR:  thr_ff    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign vin0 = '{req_data.vert0_x, req_data.vert0_y, req_data.vert0_z};
   assign vin1 = '{req_data.vert1_x, req_data.vert1_y, req_data.vert1_z};
   assign vin2 = '{req_data.vert2_x, req_data.vert2_y, req_data.vert2_z};

   always_comb begin
      for (int i = 0; i < 3; i++) dext[i] = sx(dir_ff[i]);
   end

   // ---------------------------------------------------------------- valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         for (int j = 0; j < DIV_LAT; j++) vd_ff[j] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         vd_ff[0] <= v6_ff;
         for (int j = 1; j < DIV_LAT; j++) vd_ff[j] <= vd_ff[j-1];
         rsp_valid_ff <= vd_ff[DIV_LAT-1];
      end
   end

   // ---------------------------------------------------------------- edges
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_1_ff[i] <= sx(vin1[i]) - sx(vin0[i]);
         e2_1_ff[i] <= sx(vin2[i]) - sx(vin0[i]);
         tv_1_ff[i] <= sx(org_ff[i]) - sx(vin0[i]);
      end
   end

   // ------------------------------------------------- cross product terms
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      always_ff @(posedge clock) begin
         pa_ff[i] <= dext[I1] * e2_1_ff[I2];
         pb_ff[i] <= dext[I2] * e2_1_ff[I1];
         qa_ff[i] <= tv_1_ff[I1] * e1_1_ff[I2];
         qb_ff[i] <= tv_1_ff[I2] * e1_1_ff[I1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_2_ff[i] <= e1_1_ff[i];
         e2_2_ff[i] <= e2_1_ff[i];
         tv_2_ff[i] <= tv_1_ff[i];
         pvec_ff[i] <= {pa_ff[i][2*E_W-1], pa_ff[i]} - {pb_ff[i][2*E_W-1], pb_ff[i]};
         qvec_ff[i] <= {qa_ff[i][2*E_W-1], qa_ff[i]} - {qb_ff[i][2*E_W-1], qb_ff[i]};
         e1_3_ff[i] <= e1_2_ff[i];
         e2_3_ff[i] <= e2_2_ff[i];
         tv_3_ff[i] <= tv_2_ff[i];
      end
   end

   // ------------------------------------------------------- dot products
   // wide operand split into an unsigned low half and a signed high half
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nar[DOT_DET][i] = e1_3_ff[i];
         wid[DOT_DET][i] = pvec_ff[i];
         nar[DOT_U][i]   = tv_3_ff[i];
         wid[DOT_U][i]   = pvec_ff[i];
         nar[DOT_V][i]   = dext[i];
         wid[DOT_V][i]   = qvec_ff[i];
         nar[DOT_T][i]   = e2_3_ff[i];
         wid[DOT_T][i]   = qvec_ff[i];
      end
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            lo_op[k][i] = {1'b0, wid[k][i][E_W-1:0]};
            hi_op[k][i] = wid[k][i][VEC_W-1:E_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[k][i] <= nar[k][i] * lo_op[k][i];
            hi_ff[k][i] <= nar[k][i] * hi_op[k][i];
         end
         lo_sum_ff[k] <= sx2(lo_ff[k][0]) + sx2(lo_ff[k][1]) + sx2(lo_ff[k][2]);
         hi_sum_ff[k] <= sx2(hi_ff[k][0]) + sx2(hi_ff[k][1]) + sx2(hi_ff[k][2]);
         dot_ff[k]    <= {hi_sum_ff[k], {E_W{1'b0}}} +
                         {{E_W{lo_sum_ff[k][SUM_W-1]}}, lo_sum_ff[k]};
      end
   end

   // ---------------------------------------------------- parallel test
   always_comb begin
      det_mag = dot_ff[DOT_DET][DOT_W-1] ? DOT_W'(-dot_ff[DOT_DET]) : dot_ff[DOT_DET];
      thr_ext = {{(DOT_W-THR_W-2*FRAC_BITS){1'b0}}, thr_ff, {(2*FRAC_BITS){1'b0}}};
      det_ok  = (|dot_ff[DOT_DET]) && (det_mag >= thr_ext);
   end

   always_ff @(posedge clock) begin
      ok_ff[0] <= det_ok;
      for (int j = 1; j < DIV_LAT; j++) ok_ff[j] <= ok_ff[j-1];
   end

   // ---------------------------------------------------------- quotients
   rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
      .clock (clock),
      .num   (dot_ff[DOT_U]),
      .den   (dot_ff[DOT_DET]),
      .quo   (quo_u)
   );

   rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
      .clock (clock),
      .num   (dot_ff[DOT_V]),
      .den   (dot_ff[DOT_DET]),
      .quo   (quo_v)
   );

   rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
      .clock (clock),
      .num   (dot_ff[DOT_T]),
      .den   (dot_ff[DOT_DET]),
      .quo   (quo_t)
   );

   // ------------------------------------------------------- bounds, output
   always_comb begin
      one_q  = {{(QUO_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
      uv_sum = {1'b0, quo_u} + {1'b0, quo_v};
      u_ok   = !quo_u[QUO_W-1] && (quo_u <= one_q);
      v_ok   = !quo_v[QUO_W-1] && (uv_sum <= {1'b0, one_q});
      hit    = ok_ff[DIV_LAT-1] && u_ok && v_ok;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.hit          <= hit;
      rsp_data_ff.hit_distance <= hit ? quo_t : '0;
      rsp_data_ff.bary_u       <= hit ? quo_u[BARY_W-1:0] : '0;
      rsp_data_ff.bary_v       <= hit ? quo_v[BARY_W-1:0] : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/rti_check.sv -----
// Port-level checks for the intersection pipeline, bound to the top level.
module rti_check import rti_pkg::*; #(
   parameter int LATENCY = 42
) (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_data_type rsp_data
);

   // every result traces back to a request transaction a fixed time earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching request");

   // a miss reports all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.hit_distance == '0 && rsp_data.bary_u == '0 && rsp_data.bary_v == '0)
      else $error("miss with nonzero payload");

   // no result is valid just as reset is released
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind ray_triangle_intersect rti_check #(.LATENCY(LATENCY)) u_rti_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
